### rtl/row_find_or_insert_table_defines.svh
// Assertion macros for the row find-or-insert table.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ROW_FIND_OR_INSERT_TABLE_DEFINES_SVH
`define ROW_FIND_OR_INSERT_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RFIT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define RFIT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RFIT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define RFIT_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/rfit_pkg.sv
// Shared types and constants for the row find-or-insert table.
// No dependencies; used by the request interface and all RTL modules.
`default_nettype none

package rfit_pkg;

   localparam int WORD_W        = 32;
   localparam int CFG_W         = 7;
   localparam int KEY_DIVISOR   = 10;
   localparam int KEY_WORDS_MAX = 10;

   localparam logic REQ_SEED = 1'b0;
   localparam logic REQ_FIND = 1'b1;

   typedef enum logic [1:0] {
      ST_RECV,
      ST_KEY,
      ST_WORD,
      ST_FINISH
   } rfit_state_type;

endpackage

`default_nettype wire

### rtl/rfit_req_if.sv
// Request channel: one row word per beat with valid/ready handshake.
// Depends on rfit_pkg for the word width.
`default_nettype none

interface rfit_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [rfit_pkg::WORD_W-1:0] word;
   logic                        last_word;

   modport source (output valid, output req_type, output word, output last_word,
                   input ready);
   modport sink   (input valid, input req_type, input word, input last_word,
                   output ready);
endinterface

`default_nettype wire

### rtl/rfit_rsp_if.sv
// Response channel: one lookup result per beat with valid/ready handshake.
// Widths follow the table depth of the instantiating design.
`default_nettype none

interface rfit_rsp_if #(
   parameter int IDX_W = 10,
   parameter int CNT_W = 11
);
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] row_index;
   logic             is_new;
   logic             full_res;
   logic [CNT_W-1:0] row_count;

   modport source (output valid, output row_index, output is_new, output full_res,
                   output row_count, input ready);
   modport sink   (input valid, input row_index, input is_new, input full_res,
                   input row_count, output ready);
endinterface

`default_nettype wire

### rtl/row_find_or_insert_table.sv
// Top level of the row find-or-insert table: sequencer, key store, result register.
// Depends on rfit_pkg, rfit_req_if, rfit_rsp_if, rfit_row_mem and the defines header.
`default_nettype none
`include "row_find_or_insert_table_defines.svh"

// Channel   Dir  Beat payload                              Accepted when
// req_ch    in   req_type, word, last_word                 valid && ready
// rsp_ch    out  row_index, is_new, full_res, row_count    valid && ready
// csr_*     in   csr_wdata = row_words                     csr_we
//
// Each accepted word lands directly in the row store at the slot of the next
// free index (a spare slot past the last index catches rows that arrive when
// the table is full).
// A find-or-insert row then scans the key store, one stored row per cycle; on
// a key hit the two read ports of the row store compare the stored and pending
// rows word by word.
// Reset is synchronous; stores need no clearing pass, since stored row lengths
// mask words that were never written. The result register frees the input side:
// the next row streams in while a result waits, and only its completion stalls.

module row_find_or_insert_table #(
   parameter int MAX_ROWS      = 1024,
   parameter int ROW_WORDS_MAX = 64
) (
   input  wire                         clock,
   input  wire                         reset,
   rfit_req_if.sink                    req_ch,
   rfit_rsp_if.source                  rsp_ch,
   input  wire                         csr_we,
   input  wire  [rfit_pkg::CFG_W-1:0]  csr_wdata
);

   localparam int IDX_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CNT_W      = $clog2(MAX_ROWS + 1);
   localparam int LEN_W      = $clog2(ROW_WORDS_MAX + 1);
   localparam int ROW_DEPTH  = (MAX_ROWS + 1) * ROW_WORDS_MAX;
   localparam int AW         = $clog2(ROW_DEPTH);
   localparam int KW         = rfit_pkg::WORD_W;

   // control state
   rfit_pkg::rfit_state_type state_ff, state_in;
   logic [rfit_pkg::CFG_W-1:0] row_words_ff, row_words_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [LEN_W-1:0]           wp_ff, wp_in;
   logic [KW-1:0]              run_key_ff, run_key_in;
   logic [KW-1:0]              key_ff, key_in;
   logic [LEN_W-1:0]           len_ff, len_in;
   logic [IDX_W-1:0]           d_ff, d_in;
   logic [LEN_W-1:0]           p_ff, p_in;
   logic                       found_ff, found_in;
   logic [LEN_W-1:0]           slen_ff, slen_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]           rsp_idx_ff, rsp_idx_in;
   logic                       rsp_new_ff, rsp_new_in;
   logic                       rsp_full_ff, rsp_full_in;
   logic [CNT_W-1:0]           rsp_cnt_ff, rsp_cnt_in;

   // datapath
   logic [LEN_W-1:0]           n_eff;
   logic [LEN_W-1:0]           pos;
   logic [LEN_W-1:0]           pos_p1;
   logic                       row_end;
   logic [LEN_W+3:0]           key_span;
   logic                       key_hit;
   logic [KW-1:0]              run_key_nx;
   logic [CNT_W-1:0]           d_nx;
   logic [LEN_W-1:0]           p_next;
   logic [AW-1:0]              slot_base;
   logic [AW-1:0]              wr_addr;
   logic [AW-1:0]              rd_addr_a;
   logic [AW-1:0]              rd_addr_b;
   logic                       wr_en;
   logic [KW-1:0]              rd_data_a;
   logic [KW-1:0]              rd_data_b;
   logic [KW-1:0]              word_a;
   logic [KW-1:0]              word_b;
   logic                       key_we;
   logic [IDX_W-1:0]           key_raddr;
   logic [LEN_W+KW-1:0]        key_rd_ff;
   logic [LEN_W+KW-1:0]        key_mem [MAX_ROWS];

   // effective row length: zero acts as one, clamp to the store width
   always_comb begin
      if (row_words_ff == '0) begin
         n_eff = LEN_W'(1);
      end else if (int'(row_words_ff) > ROW_WORDS_MAX) begin
         n_eff = LEN_W'(ROW_WORDS_MAX);
      end else begin
         n_eff = LEN_W'(row_words_ff);
      end
   end

   // a shortened length folds late words onto the last position
   assign pos     = (wp_ff >= n_eff) ? n_eff - LEN_W'(1) : wp_ff;
   assign pos_p1  = pos + LEN_W'(1);
   assign row_end = req_ch.last_word || (pos_p1 >= n_eff);

   // pos < clamp(n/10, 1, 10)  <=>  pos == 0, or pos < 10 and 10*(pos+1) <= n
   assign key_span = (LEN_W + 4)'(pos_p1) * (LEN_W + 4)'(rfit_pkg::KEY_DIVISOR);
   assign key_hit  = (pos == '0) ||
                     ((int'(pos) < rfit_pkg::KEY_WORDS_MAX) &&
                      (key_span <= (LEN_W + 4)'(n_eff)));
   assign run_key_nx = key_hit ? (run_key_ff ^ req_ch.word) : run_key_ff;

   assign d_nx = CNT_W'(d_ff) + CNT_W'(1);

   // row store addressing: pending row lives in the slot of the next free index
   assign slot_base = AW'(count_ff) * AW'(ROW_WORDS_MAX);
   assign p_next    = (state_ff == rfit_pkg::ST_WORD) ? p_ff + LEN_W'(1) : '0;
   assign wr_en     = (state_ff == rfit_pkg::ST_RECV) && req_ch.valid;
   assign wr_addr   = slot_base + AW'(pos);
   assign rd_addr_a = AW'(d_ff) * AW'(ROW_WORDS_MAX) + AW'(p_next);
   assign rd_addr_b = slot_base + AW'(p_next);

   // next key read: entry 0 when a row completes, else the entry after d
   assign key_raddr = ((state_ff == rfit_pkg::ST_KEY) || (state_ff == rfit_pkg::ST_WORD)) ?
                      d_nx[IDX_W-1:0] : '0;

   // words past a row's stored length read as zero
   assign word_a = (p_ff < slen_ff) ? rd_data_a : '0;
   assign word_b = (p_ff < len_ff)  ? rd_data_b : '0;

   rfit_row_mem #(
      .DEPTH     (ROW_DEPTH),
      .AW        (AW)
   ) u_row_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req_ch.word),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // key store: {stored length, key}; written only on append, read ahead of scan.
   // Writes and reads never touch the same entry in flight, so no forwarding.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[count_ff[IDX_W-1:0]] <= {len_ff, key_ff};
      end
      key_rd_ff <= key_mem[key_raddr];
   end

   assign req_ch.ready     = (state_ff == rfit_pkg::ST_RECV);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.row_index = rsp_idx_ff;
   assign rsp_ch.is_new    = rsp_new_ff;
   assign rsp_ch.full_res  = rsp_full_ff;
   assign rsp_ch.row_count = rsp_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfit_pkg::ST_RECV;
      end else begin
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_words_ff <= rfit_pkg::CFG_W'(1);
         count_ff     <= '0;
         wp_ff        <= '0;
         run_key_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_words_ff <= row_words_in;
         count_ff     <= count_in;
         wp_ff        <= wp_in;
         run_key_ff   <= run_key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      len_ff      <= len_in;
      d_ff        <= d_in;
      p_ff        <= p_in;
      found_ff    <= found_in;
      slen_ff     <= slen_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_full_ff <= rsp_full_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   always_comb begin
      state_in     = state_ff;
      row_words_in = csr_we ? csr_wdata : row_words_ff;
      count_in     = count_ff;
      wp_in        = wp_ff;
      run_key_in   = run_key_ff;
      key_in       = key_ff;
      len_in       = len_ff;
      d_in         = d_ff;
      p_in         = p_ff;
      found_in     = found_ff;
      slen_in      = slen_ff;
      key_we       = 1'b0;
      // drop the held result once taken
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      case (state_ff)
         rfit_pkg::ST_RECV: begin
            if (req_ch.valid) begin
               wp_in      = pos_p1;
               run_key_in = run_key_nx;
               if (row_end) begin
                  // close the row: latch key and the highest written position
                  wp_in      = '0;
                  run_key_in = '0;
                  key_in     = run_key_nx;
                  len_in     = (wp_ff > pos_p1) ? wp_ff : pos_p1;
                  d_in       = '0;
                  found_in   = 1'b0;
                  if ((req_ch.req_type == rfit_pkg::REQ_FIND) && (count_ff != '0)) begin
                     state_in = rfit_pkg::ST_KEY;
                  end else begin
                     state_in = rfit_pkg::ST_FINISH;
                  end
               end
            end
         end
         rfit_pkg::ST_KEY: begin
            if (key_rd_ff[KW-1:0] == key_ff) begin
               slen_in  = key_rd_ff[LEN_W+KW-1:KW];
               p_in     = '0;
               state_in = rfit_pkg::ST_WORD;
            end else if (d_nx == count_ff) begin
               state_in = rfit_pkg::ST_FINISH;
            end else begin
               d_in = d_nx[IDX_W-1:0];
            end
         end
         rfit_pkg::ST_WORD: begin
            if (word_a != word_b) begin
               // advance to the next stored row
               if (d_nx == count_ff) begin
                  state_in = rfit_pkg::ST_FINISH;
               end else begin
                  d_in     = d_nx[IDX_W-1:0];
                  state_in = rfit_pkg::ST_KEY;
               end
            end else if (p_ff + LEN_W'(1) == n_eff) begin
               found_in = 1'b1;
               state_in = rfit_pkg::ST_FINISH;
            end else begin
               p_in = p_ff + LEN_W'(1);
            end
         end
         rfit_pkg::ST_FINISH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               state_in     = rfit_pkg::ST_RECV;
               if (found_ff) begin
                  rsp_idx_in  = d_ff;
                  rsp_new_in  = 1'b0;
                  rsp_full_in = 1'b0;
                  rsp_cnt_in  = count_ff;
               end else if (count_ff < CNT_W'(MAX_ROWS)) begin
                  key_we      = 1'b1;
                  count_in    = count_ff + CNT_W'(1);
                  rsp_idx_in  = count_ff[IDX_W-1:0];
                  rsp_new_in  = 1'b1;
                  rsp_full_in = 1'b0;
                  rsp_cnt_in  = count_ff + CNT_W'(1);
               end else begin
                  rsp_idx_in  = '0;
                  rsp_new_in  = 1'b0;
                  rsp_full_in = 1'b1;
                  rsp_cnt_in  = count_ff;
               end
            end
         end
         default: begin
            state_in = rfit_pkg::ST_RECV;
         end
      endcase
   end

   `RFIT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_ROWS), "row count past table depth")
   `RFIT_ASSERT_IMP(a_scan_in_range, clock, reset, (state_ff == rfit_pkg::ST_KEY) || (state_ff == rfit_pkg::ST_WORD), CNT_W'(d_ff) < count_ff, "scan index beyond stored rows")
   `RFIT_ASSERT_NXT(a_append_counts, clock, reset, key_we, count_ff == $past(count_ff) + CNT_W'(1), "append did not advance row count")
   `RFIT_ASSERT_IMP(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == rfit_pkg::ST_FINISH, "result raised outside finish step")

endmodule

`default_nettype wire

### rtl/rfit_row_mem.sv
// Row word store: one write port, two registered read ports.
// Depends on rfit_pkg for the word width.
`default_nettype none

module rfit_row_mem #(
   parameter int DEPTH = 65600,
   parameter int AW    = 17
) (
   input  wire                         clock,
   input  wire                         wr_en,
   input  wire  [AW-1:0]               wr_addr,
   input  wire  [rfit_pkg::WORD_W-1:0] wr_data,
   input  wire  [AW-1:0]               rd_addr_a,
   input  wire  [AW-1:0]               rd_addr_b,
   output logic [rfit_pkg::WORD_W-1:0] rd_data_a,
   output logic [rfit_pkg::WORD_W-1:0] rd_data_b
);

   logic [rfit_pkg::WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

### test/row_find_or_insert_table_checker.sv
`timescale 1ns / 100ps
// Result checker for the row find-or-insert table: follows the request, result and
// register ports, predicts each lookup result and compares it field by field.
// Depends on rfit_pkg for the request codes, widths and the key rule constants.

module row_find_or_insert_table_checker #(
   parameter int MAX_ROWS      = 1024,
   parameter int ROW_WORDS_MAX = 64,
   parameter int IDX_W         = 10,
   parameter int CNT_W         = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_type,
   input  logic [rfit_pkg::WORD_W-1:0] req_word,
   input  logic                        req_last_word,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [IDX_W-1:0]            rsp_row_index,
   input  logic                        rsp_is_new,
   input  logic                        rsp_full_res,
   input  logic [CNT_W-1:0]            rsp_row_count,
   input  logic                        csr_we,
   input  logic [rfit_pkg::CFG_W-1:0]  csr_wdata,
   output int                          mismatches,
   output int                          results_waiting,
   output int                          rows_held,
   output int                          hits_seen,
   output int                          appends_seen,
   output int                          refusals_seen
);
   import rfit_pkg::*;

   typedef logic [WORD_W-1:0] word_t;

   typedef struct packed {
      logic [IDX_W-1:0] row_index;
      logic             is_new;
      logic             full_res;
      logic [CNT_W-1:0] row_count;
   } lookup_t;

   word_t            table_words [MAX_ROWS*ROW_WORDS_MAX];
   word_t            table_keys [MAX_ROWS];
   int unsigned      table_rows;
   word_t            open_row [ROW_WORDS_MAX];
   word_t            open_key;
   int unsigned      open_pos;
   logic [CFG_W-1:0] row_words;
   lookup_t          lookups_due [$];
   int               errors   = 0;
   int               hits     = 0;
   int               appends  = 0;
   int               refusals = 0;

   function automatic int unsigned span_of(logic [CFG_W-1:0] setting);
      if (setting == 0) return 1;
      if (setting > ROW_WORDS_MAX) return ROW_WORDS_MAX;
      return setting;
   endfunction

   function automatic int unsigned key_words(int unsigned n);
      int unsigned h;
      h = n / KEY_DIVISOR;
      if (h < 1) h = 1;
      if (h > KEY_WORDS_MAX) h = KEY_WORDS_MAX;
      return h;
   endfunction

   function automatic void clear_open_row();
      foreach (open_row[i]) open_row[i] = '0;
      open_key = '0;
      open_pos = 0;
   endfunction

   // Fold one accepted word into the open row; when the row ends, queue its lookup.
   function automatic void take_word(logic kind, word_t w, logic fin);
      int unsigned n, pos, d, i;
      logic        found, stored, same;
      lookup_t     res;
      n   = span_of(row_words);
      pos = (open_pos >= n) ? n - 1 : open_pos;
      open_row[pos] = w;
      if (pos < key_words(n)) open_key ^= w;
      if (!fin && pos + 1 < n) begin
         open_pos = pos + 1;
         return;
      end
      found  = 1'b0;
      stored = 1'b0;
      res    = '0;
      if (kind == REQ_FIND) begin
         for (d = 0; d < table_rows && !found; d++) begin
            if (table_keys[d] == open_key) begin
               same = 1'b1;
               for (i = 0; i < n; i++)
                  if (table_words[d*ROW_WORDS_MAX + i] != open_row[i]) same = 1'b0;
               if (same) begin
                  found = 1'b1;
                  res.row_index = IDX_W'(d);
               end
            end
         end
      end
      if (!found && table_rows < MAX_ROWS) begin
         // stored rows keep every word; unused ones stay zero
         for (i = 0; i < ROW_WORDS_MAX; i++)
            table_words[table_rows*ROW_WORDS_MAX + i] = open_row[i];
         table_keys[table_rows] = open_key;
         res.row_index = IDX_W'(table_rows);
         table_rows++;
         stored = 1'b1;
      end
      res.is_new    = stored;
      res.full_res  = !found && !stored;
      res.row_count = CNT_W'(table_rows);
      lookups_due.push_back(res);
      clear_open_row();
   endfunction

   function automatic void check_result();
      lookup_t want;
      if (lookups_due.size() == 0) begin
         $error("result beat with nothing expected: row_index %0d is_new %0b full_res %0b row_count %0d",
                rsp_row_index, rsp_is_new, rsp_full_res, rsp_row_count);
         errors++;
         return;
      end
      want = lookups_due.pop_front();
      if (rsp_row_index !== want.row_index) begin
         $error("row_index: expected %0d, got %0d", want.row_index, rsp_row_index);
         errors++;
      end
      if (rsp_is_new !== want.is_new) begin
         $error("is_new: expected %0b, got %0b", want.is_new, rsp_is_new);
         errors++;
      end
      if (rsp_full_res !== want.full_res) begin
         $error("full_res: expected %0b, got %0b", want.full_res, rsp_full_res);
         errors++;
      end
      if (rsp_row_count !== want.row_count) begin
         $error("row_count: expected %0d, got %0d", want.row_count, rsp_row_count);
         errors++;
      end
      if (want.full_res) refusals++;
      else if (want.is_new) appends++;
      else hits++;
   endfunction

   // Retire the result first, so a beat never meets an expectation queued at its own edge.
   always @(posedge clock) begin
      if (reset) begin
         table_rows = 0;
         row_words  = 1;
         clear_open_row();
         lookups_due.delete();
      end else begin
         if (csr_we) row_words = csr_wdata;
         if (rsp_valid && rsp_ready) check_result();
         if (req_valid && req_ready) take_word(req_type, req_word, req_last_word);
      end
      mismatches      <= errors;
      results_waiting <= lookups_due.size();
      rows_held       <= table_rows;
      hits_seen       <= hits;
      appends_seen    <= appends;
      refusals_seen   <= refusals;
   end

endmodule

### test/row_find_or_insert_table_test.sv
`timescale 1ns / 100ps
// Testbench top for the row find-or-insert table: clock, reset, row stimulus,
// result-side stalls, watchdog and verdict. Depends on rfit_pkg, both channel
// interfaces, the block and row_find_or_insert_table_checker.

module row_find_or_insert_table_test;
   import rfit_pkg::*;

   localparam int MAX_ROWS       = 1024;
   localparam int ROW_WORDS_MAX  = 64;
   localparam int IDX_W          = $clog2(MAX_ROWS);
   localparam int CNT_W          = $clog2(MAX_ROWS + 1);
   localparam int POOL_ROWS      = 48;
   localparam int PHASE_BEATS    = 40;
   localparam int PHASE_COUNT    = 12;
   localparam int FULL_PROBES    = 40;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 64;
   // a full table whose keys all collide gives the longest scan per row
   localparam int WATCHDOG_LIMIT = 200000;

   typedef enum int {RX_OPEN, RX_MOSTLY, RX_HALF, RX_SPARSE} rx_pattern_t;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CFG_W-1:0] csr_wdata;

   rfit_req_if                                 req_ch ();
   rfit_rsp_if #(.IDX_W(IDX_W), .CNT_W(CNT_W)) rsp_ch ();

   int mismatches, results_waiting, rows_held;
   int hits_seen, appends_seen, refusals_seen;

   // row lengths visited by the random phases, out-of-range settings included
   int phase_setting [PHASE_COUNT] = '{1, 64, 2, 127, 20, 5, 0, 33, 10, 9, 3, 1};

   // rows sent earlier, kept zero-extended so they can be replayed or mutated
   logic [WORD_W-1:0] pool_words [POOL_ROWS][ROW_WORDS_MAX];
   int                pool_count = 0;
   int                pool_next  = 0;

   // row being built for the next send
   logic [WORD_W-1:0] row_buf [ROW_WORDS_MAX];
   int                row_len;
   logic              row_kind;
   logic              row_fin;

   int cur_len          = 1;
   int beats_sent       = 0;
   int burst_left       = 0;
   bit hold_off_request = 1'b0;

   row_find_or_insert_table #(
      .MAX_ROWS      (MAX_ROWS),
      .ROW_WORDS_MAX (ROW_WORDS_MAX)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   row_find_or_insert_table_checker #(
      .MAX_ROWS      (MAX_ROWS),
      .ROW_WORDS_MAX (ROW_WORDS_MAX),
      .IDX_W         (IDX_W),
      .CNT_W         (CNT_W)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_type        (req_ch.req_type),
      .req_word        (req_ch.word),
      .req_last_word   (req_ch.last_word),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_row_index   (rsp_ch.row_index),
      .rsp_is_new      (rsp_ch.is_new),
      .rsp_full_res    (rsp_ch.full_res),
      .rsp_row_count   (rsp_ch.row_count),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .results_waiting (results_waiting),
      .rows_held       (rows_held),
      .hits_seen       (hits_seen),
      .appends_seen    (appends_seen),
      .refusals_seen   (refusals_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one beat and hold it until the block takes it. Bursts of random length
   // are separated by random gaps; a third of the bursts run back to back.
   task automatic push_beat(input logic kind, input logic [WORD_W-1:0] w, input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= kind;
      req_ch.word      <= w;
      req_ch.last_word <= fin;
      // ready read right after the edge is still the value the edge sampled
      do @(posedge clock); while (!req_ch.ready);
      beats_sent++;
   endtask

   // Drop valid and hold until every queued lookup has come back.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_waiting != 0) @(posedge clock);
   endtask

   // Write the row length only on an idle block, after a short settle.
   task automatic write_row_words(input int setting);
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= CFG_W'(setting);
      @(posedge clock);
      csr_we <= 1'b0;
      if (setting == 0) cur_len = 1;
      else if (setting > ROW_WORDS_MAX) cur_len = ROW_WORDS_MAX;
      else cur_len = setting;
   endtask

   // Send row_buf; the leading words carry a random request kind, the final one decides.
   task automatic push_row();
      int i;
      for (i = 0; i < row_len; i++) begin
         if (i == row_len - 1) push_beat(row_kind, row_buf[i], row_fin);
         else push_beat(1'($urandom_range(0, 1)), row_buf[i], 1'b0);
      end
      for (i = 0; i < ROW_WORDS_MAX; i++)
         pool_words[pool_next][i] = (i < row_len) ? row_buf[i] : '0;
      pool_next = (pool_next + 1) % POOL_ROWS;
      if (pool_count < POOL_ROWS) pool_count++;
   endtask

   // Zeros, ones and tiny values make keys collide, so the word compare gets exercised.
   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return WORD_W'($urandom_range(0, 3));
         default: return $urandom;
      endcase
   endfunction

   // Build a row of n words: replay of an earlier row (hit expected when it was stored),
   // a near miss with one bit flipped, a fresh row, or a fresh row cut short.
   function automatic void make_row(input int n);
      int pick, slot, i, k;
      pick = $urandom_range(0, 99);
      if (pool_count > 0 && pick < 45) begin
         slot    = $urandom_range(0, pool_count - 1);
         row_len = n;
         for (i = 0; i < n; i++) row_buf[i] = pool_words[slot][i];
         if (pick < 15) begin
            k = $urandom_range(0, n - 1);
            row_buf[k][$urandom_range(0, WORD_W - 1)] ^= 1'b1;
         end
      end else begin
         row_len = (pick >= 88) ? $urandom_range(1, n) : n;
         for (i = 0; i < row_len; i++) row_buf[i] = rand_word();
      end
      // a short row must be closed by last_word; a full one may end on length alone
      row_fin  = (row_len < n) ? 1'b1 : 1'($urandom_range(0, 1));
      row_kind = ($urandom_range(0, 3) == 0) ? REQ_SEED : REQ_FIND;
   endfunction

   // One random phase at a given row length; optionally squeeze the result side first.
   task automatic run_phase(input int setting, input bit squeeze);
      int spent, rows;
      write_row_words(setting);
      if (squeeze) hold_off_request = 1'b1;
      spent = 0;
      rows  = 0;
      while (spent < PHASE_BEATS || rows < 2) begin
         make_row(cur_len);
         push_row();
         spent += row_len;
         rows++;
         // now and then, pause the sender until everything is back
         if ($urandom_range(0, 31) == 0) wait_idle();
      end
   endtask

   initial begin : stimulus
      int p, probe;
      req_ch.valid     <= 1'b0;
      req_ch.req_type  <= REQ_SEED;
      req_ch.word      <= '0;
      req_ch.last_word <= 1'b0;
      csr_we           <= 1'b0;
      csr_wdata        <= '0;
      reset            <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: one-word rows at the reset length, word extremes, both kinds.
      push_beat(REQ_SEED, 32'h0000_0000, 1'b1);
      push_beat(REQ_FIND, 32'h0000_0000, 1'b1);
      push_beat(REQ_FIND, 32'hFFFF_FFFF, 1'b0);    // ends on length, not on last_word
      push_beat(REQ_SEED, 32'hFFFF_FFFF, 1'b1);    // duplicate seed stored anyway
      push_beat(REQ_FIND, 32'hFFFF_FFFF, 1'b1);    // first copy wins

      // Length zero acts as one word.
      write_row_words(0);
      push_beat(REQ_FIND, 32'h1234_5678, 1'b0);
      push_beat(REQ_FIND, 32'h1234_5678, 1'b1);

      // Four-word rows: the final word's kind decides, leading kinds disagree.
      write_row_words(4);
      push_beat(REQ_FIND, 32'hA5A5_0001, 1'b0);
      push_beat(REQ_FIND, 32'h5A5A_0002, 1'b0);
      push_beat(REQ_FIND, 32'hC3C3_0003, 1'b0);
      push_beat(REQ_SEED, 32'h3C3C_0004, 1'b0);
      // cut short: same key as the seeded row, but the missing words count as zero
      push_beat(REQ_SEED, 32'hA5A5_0001, 1'b0);
      push_beat(REQ_FIND, 32'h5A5A_0002, 1'b1);
      push_beat(REQ_SEED, 32'hA5A5_0001, 1'b0);
      push_beat(REQ_SEED, 32'h5A5A_0002, 1'b0);
      push_beat(REQ_SEED, 32'hC3C3_0003, 1'b0);
      push_beat(REQ_FIND, 32'h3C3C_0004, 1'b1);
      push_beat(REQ_FIND, 32'hA5A5_0001, 1'b0);
      push_beat(REQ_FIND, 32'h5A5A_0002, 1'b0);
      push_beat(REQ_FIND, 32'h0000_0000, 1'b0);
      push_beat(REQ_FIND, 32'h0000_0000, 1'b0);

      // Over-range length acts as the maximum; rows stored short must still match.
      write_row_words(127);
      push_beat(REQ_FIND, 32'h0000_0000, 1'b1);
      push_beat(REQ_FIND, 32'hFFFF_FFFF, 1'b1);

      // Random phases; squeeze the result side in the first and last one.
      for (p = 0; p < PHASE_COUNT; p++)
         run_phase(phase_setting[p], p == 0 || p == PHASE_COUNT - 1);

      // Fill the table with one-word seeds, then probe it while full.
      write_row_words(1);
      while (rows_held < MAX_ROWS) begin
         row_len  = 1;
         row_buf[0] = rand_word();
         row_kind = REQ_SEED;
         row_fin  = 1'($urandom_range(0, 1));
         push_row();
      end
      for (probe = 0; probe < FULL_PROBES; probe++) begin
         make_row(1);
         push_row();
      end

      // Drain, then give the block its latency before the verdict.
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d request beats and %0d results: %0d found, %0d appended, %0d refused.",
               beats_sent, hits_seen + appends_seen + refusals_seen,
               hits_seen, appends_seen, refusals_seen);
      $display("Row lengths 1 to %0d visited; table ended holding %0d rows.",
               ROW_WORDS_MAX, rows_held);
      if (mismatches == 0 && results_waiting == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Result-side stalls: patterns of random length, plus a long hold-off on request.
   initial begin : result_stalls
      int          stall_left;
      int          mode_left;
      rx_pattern_t mode;
      stall_left = 0;
      mode_left  = 0;
      mode       = RX_OPEN;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode      = rx_pattern_t'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 160);
         end
         mode_left--;
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               RX_OPEN:   rsp_ch.ready <= 1'b1;
               RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               RX_HALF:   rsp_ch.ready <= 1'($urandom_range(0, 1));
               default:   rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // Watchdog: end the run when no beat moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

endmodule
